### hdl/ray_march_circle_occlusion_macros.svh
// Assertion helpers used by the checker file.
`ifndef RAY_MARCH_CIRCLE_OCCLUSION_MACROS_SVH
`define RAY_MARCH_CIRCLE_OCCLUSION_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RMCO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RMCO_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/rmco_pkg.sv
package rmco_pkg;

    // Geometry and angle resolution
    localparam int ANGLE_STEPS       = 256;
    localparam int SCREEN_WIDTH      = 800;
    localparam int SCREEN_HEIGHT     = 600;
    localparam int MAX_STEPS_DEFAULT = 2048;

    // Field widths
    localparam int XY_W     = 10;
    localparam int RAD_W    = 8;
    localparam int CNT_W    = 2;
    localparam int IDX_W    = 8;
    localparam int OUT_W    = 11;
    localparam int DRAWN_W  = 11;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [DRAWN_W-1:0] DRAWN_MAX = {DRAWN_W{1'b1}};

    // CORDIC: Q30 angle fraction of a quarter turn, Q30 vector
    localparam int CORDIC_ITERS = 18;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_FRAC  = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [CORDIC_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215
    };

    // Position is signed Q16
    localparam int FRAC_W      = 16;
    localparam int ROUND_SHIFT = CORDIC_FRAC - FRAC_W;
    localparam logic signed [CORDIC_W-1:0] ROUND_BIAS = CORDIC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam int DIR_W       = CORDIC_W - ROUND_SHIFT;

    localparam int SPAN_MAX   = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int COORD_SPAN = ((SPAN_MAX > (2**XY_W - 1)) ? SPAN_MAX : (2**XY_W - 1)) + 3;
    localparam int COORD_W    = $clog2(COORD_SPAN) + 1;
    localparam int POS_W      = COORD_W + FRAC_W;
    localparam int MAG_W      = POS_W - 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RSQ_W      = 2 * RAD_W;

    localparam logic signed [POS_W-1:0] X_LIMIT = POS_W'(SCREEN_WIDTH) <<< FRAC_W;
    localparam logic signed [POS_W-1:0] Y_LIMIT = POS_W'(SCREEN_HEIGHT) <<< FRAC_W;

    // Register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_OBST_COUNT = 3'd0,
        REG_A_X        = 3'd1,
        REG_A_Y        = 3'd2,
        REG_A_RADIUS   = 3'd3,
        REG_B_X        = 3'd4,
        REG_B_Y        = 3'd5,
        REG_B_RADIUS   = 3'd6
    } reg_idx_t;

    localparam logic [CNT_W-1:0] RST_COUNT    = 2'd2;
    localparam logic [XY_W-1:0]  RST_A_X      = 10'd50;
    localparam logic [XY_W-1:0]  RST_A_Y      = 10'd50;
    localparam logic [RAD_W-1:0] RST_A_RADIUS = 8'd10;
    localparam logic [XY_W-1:0]  RST_B_X      = 10'd400;
    localparam logic [XY_W-1:0]  RST_B_Y      = 10'd300;
    localparam logic [RAD_W-1:0] RST_B_RADIUS = 8'd20;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [XY_W-1:0]  a_x;
        logic [XY_W-1:0]  a_y;
        logic [RAD_W-1:0] a_radius;
        logic [XY_W-1:0]  b_x;
        logic [XY_W-1:0]  b_y;
        logic [RAD_W-1:0] b_radius;
    } obst_cfg_t;

    typedef struct packed {
        logic                start;
        logic [CORDIC_W-1:0] phase;
    } cordic_req_t;

    typedef struct packed {
        logic                    valid;
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
    } dir_t;

    // Angle index to 32-bit turn fraction, built at elaboration
    localparam int PHASE_DEPTH = 2**IDX_W;
    typedef logic [CORDIC_W-1:0] phase_table_t [PHASE_DEPTH];

    function automatic phase_table_t build_phase_table();
        phase_table_t t;
        logic [63:0]  wrapped;
        for (int i = 0; i < PHASE_DEPTH; i++)
        begin
            wrapped = 64'(i % ANGLE_STEPS);
            t[i] = CORDIC_W'((wrapped << 32) / 64'(ANGLE_STEPS));
        end
        return t;
    endfunction

    localparam phase_table_t PHASE_TABLE = build_phase_table();

    // Q16 to whole pixels, truncating toward zero
    function automatic logic [OUT_W-1:0] trunc_pixel(input logic signed [POS_W-1:0] pos);
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] whole;
        mag   = pos[POS_W-1] ? POS_W'(-pos) : POS_W'(pos);
        whole = mag >> FRAC_W;
        if (pos[POS_W-1])
        begin
            whole = POS_W'(-whole);
        end
        return whole[OUT_W-1:0];
    endfunction

endpackage

### hdl/ray_march_circle_occlusion.sv
// Channel   Handshake                    Payload
// ray       ray_valid / ray_ready        origin_x, origin_y, ray_index
// result    result_valid / result_ready  end_x, end_y, hit, drawn_points, step_cap_reached
// config    APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// A ray passes through the accept state, the iterative CORDIC, the first step
// taken straight from the CORDIC result, then a square stage and a circle/bounds
// test for each step, and finally the output register. The step loop through the
// squaring stage sets the per-pixel cost.
// Reset is asynchronous, active low; config registers return to their reset values.
// A new ray is taken while a finished result still waits; a finished ray holds
// until the output register is free.
module ray_march_circle_occlusion #(
    parameter int MAX_STEPS = rmco_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ray_valid,
    output logic                              ray_ready,
    input  logic [rmco_pkg::XY_W-1:0]         origin_x,
    input  logic [rmco_pkg::XY_W-1:0]         origin_y,
    input  logic [rmco_pkg::IDX_W-1:0]        ray_index,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [rmco_pkg::OUT_W-1:0] end_x,
    output logic signed [rmco_pkg::OUT_W-1:0] end_y,
    output logic                              hit,
    output logic [rmco_pkg::DRAWN_W-1:0]      drawn_points,
    output logic                              step_cap_reached,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rmco_pkg::ADDR_W-1:0]       paddr,
    input  logic [rmco_pkg::DATA_W-1:0]       pwdata,
    output logic [rmco_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import rmco_pkg::*;

    obst_cfg_t   cfg;
    cordic_req_t cordic_req;
    dir_t        dir;

    rmco_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rmco_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .dir   (dir)
    );

    rmco_march #(
        .MAX_STEPS (MAX_STEPS)
    ) u_march (
        .clk              (clk),
        .rst_n            (rst_n),
        .ray_valid        (ray_valid),
        .ray_ready        (ray_ready),
        .origin_x         (origin_x),
        .origin_y         (origin_y),
        .ray_index        (ray_index),
        .cfg              (cfg),
        .cordic_req       (cordic_req),
        .dir              (dir),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .end_x            (end_x),
        .end_y            (end_y),
        .hit              (hit),
        .drawn_points     (drawn_points),
        .step_cap_reached (step_cap_reached)
    );

endmodule

### hdl/rmco_regs.sv
module rmco_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmco_pkg::ADDR_W-1:0]   paddr,
    input  logic [rmco_pkg::DATA_W-1:0]   pwdata,
    output logic [rmco_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rmco_pkg::obst_cfg_t           cfg
);
    import rmco_pkg::*;

    obst_cfg_t cfg_reg;
    reg_idx_t  reg_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count    <= RST_COUNT;
            cfg_reg.a_x      <= RST_A_X;
            cfg_reg.a_y      <= RST_A_Y;
            cfg_reg.a_radius <= RST_A_RADIUS;
            cfg_reg.b_x      <= RST_B_X;
            cfg_reg.b_y      <= RST_B_Y;
            cfg_reg.b_radius <= RST_B_RADIUS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OBST_COUNT: cfg_reg.count    <= pwdata[CNT_W-1:0];
                REG_A_X:        cfg_reg.a_x      <= pwdata[XY_W-1:0];
                REG_A_Y:        cfg_reg.a_y      <= pwdata[XY_W-1:0];
                REG_A_RADIUS:   cfg_reg.a_radius <= pwdata[RAD_W-1:0];
                REG_B_X:        cfg_reg.b_x      <= pwdata[XY_W-1:0];
                REG_B_Y:        cfg_reg.b_y      <= pwdata[XY_W-1:0];
                REG_B_RADIUS:   cfg_reg.b_radius <= pwdata[RAD_W-1:0];
                default:        cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OBST_COUNT: prdata = DATA_W'(cfg_reg.count);
            REG_A_X:        prdata = DATA_W'(cfg_reg.a_x);
            REG_A_Y:        prdata = DATA_W'(cfg_reg.a_y);
            REG_A_RADIUS:   prdata = DATA_W'(cfg_reg.a_radius);
            REG_B_X:        prdata = DATA_W'(cfg_reg.b_x);
            REG_B_Y:        prdata = DATA_W'(cfg_reg.b_y);
            REG_B_RADIUS:   prdata = DATA_W'(cfg_reg.b_radius);
            default:        prdata = '0;
        endcase
    end

endmodule

### hdl/rmco_cordic.sv
module rmco_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmco_pkg::cordic_req_t req,
    output rmco_pkg::dir_t        dir
);
    import rmco_pkg::*;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    logic                       busy_reg;
    logic                       done_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    quad_t                      quad_reg;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] atan_val;
    logic signed [CORDIC_W-1:0] c_full;
    logic signed [CORDIC_W-1:0] s_full;
    logic signed [DIR_W-1:0]    c;
    logic signed [DIR_W-1:0]    s;

    // shared shifter: one micro-rotation per cycle
    assign xs       = x_reg >>> iter_reg;
    assign ys       = y_reg >>> iter_reg;
    assign atan_val = $signed(ATAN_TURNS[iter_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= $signed({2'b00, req.phase[CORDIC_FRAC-1:0]});
                quad_reg <= quad_t'(req.phase[CORDIC_W-1:CORDIC_FRAC]);
                iter_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_val;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_val;
                end
                if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    // round Q30 to Q16
    assign c_full = (x_reg + ROUND_BIAS) >>> ROUND_SHIFT;
    assign s_full = (y_reg + ROUND_BIAS) >>> ROUND_SHIFT;
    assign c      = c_full[DIR_W-1:0];
    assign s      = s_full[DIR_W-1:0];

    always_comb
    begin
        dir.valid = done_reg;
        unique case (quad_reg)
            QUAD_0:
            begin
                dir.x = c;
                dir.y = s;
            end
            QUAD_90:
            begin
                dir.x = -s;
                dir.y = c;
            end
            QUAD_180:
            begin
                dir.x = -c;
                dir.y = -s;
            end
            QUAD_270:
            begin
                dir.x = s;
                dir.y = -c;
            end
            default:
            begin
                dir.x = c;
                dir.y = s;
            end
        endcase
    end

endmodule

### hdl/rmco_march.sv
module rmco_march #(
    parameter int MAX_STEPS = rmco_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           ray_valid,
    output logic                           ray_ready,
    input  logic [rmco_pkg::XY_W-1:0]      origin_x,
    input  logic [rmco_pkg::XY_W-1:0]      origin_y,
    input  logic [rmco_pkg::IDX_W-1:0]     ray_index,
    input  rmco_pkg::obst_cfg_t            cfg,
    output rmco_pkg::cordic_req_t          cordic_req,
    input  rmco_pkg::dir_t                 dir,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic signed [rmco_pkg::OUT_W-1:0] end_x,
    output logic signed [rmco_pkg::OUT_W-1:0] end_y,
    output logic                           hit,
    output logic [rmco_pkg::DRAWN_W-1:0]   drawn_points,
    output logic                           step_cap_reached
);
    import rmco_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;
    localparam logic [2*FRAC_W-1:0] SQ_FRAC_ZERO = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_SQ,
        S_TEST,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [POS_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg;
    logic [SQ_W-1:0]         sq_ax_reg, sq_ay_reg, sq_bx_reg, sq_by_reg;
    logic [RSQ_W-1:0]        rsq_a_reg, rsq_b_reg;
    logic                    en_a_reg, en_b_reg;
    logic [STEP_W-1:0]       steps_reg;
    logic [DRAWN_W-1:0]      drawn_reg;
    logic                    hit_reg, cap_reg;

    logic                    result_valid_reg;
    logic [OUT_W-1:0]        end_x_reg, end_y_reg;
    logic                    hit_out_reg, cap_out_reg;
    logic [DRAWN_W-1:0]      drawn_out_reg;

    logic                    accept;
    logic signed [POS_W-1:0] px_init, py_init;
    logic signed [POS_W-1:0] step_x, step_y;
    logic [MAG_W-1:0]        mag_ax, mag_ay, mag_bx, mag_by;
    logic [SUM_W-1:0]        sum_a, sum_b, lim_a, lim_b;
    logic                    hit_any, out_of_bounds, last_step, out_free, emit;
    logic [DRAWN_W-1:0]      drawn_next;

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [POS_W-1:0] v);
        return v[POS_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    assign accept    = (state_reg == S_IDLE) && ray_valid;
    assign ray_ready = (state_reg == S_IDLE);

    assign cordic_req.start = accept;
    assign cordic_req.phase = PHASE_TABLE[ray_index];

    assign px_init = $signed(POS_W'({origin_x, FRAC_ZERO}));
    assign py_init = $signed(POS_W'({origin_y, FRAC_ZERO}));

    // first step comes straight from the CORDIC, later ones from the held direction
    assign step_x = (state_reg == S_DIR) ? POS_W'(dir.x) : POS_W'(dir_x_reg);
    assign step_y = (state_reg == S_DIR) ? POS_W'(dir.y) : POS_W'(dir_y_reg);

    assign mag_ax = magnitude(dax_reg);
    assign mag_ay = magnitude(day_reg);
    assign mag_bx = magnitude(dbx_reg);
    assign mag_by = magnitude(dby_reg);

    assign sum_a = SUM_W'(sq_ax_reg) + SUM_W'(sq_ay_reg);
    assign sum_b = SUM_W'(sq_bx_reg) + SUM_W'(sq_by_reg);
    assign lim_a = SUM_W'({rsq_a_reg, SQ_FRAC_ZERO});
    assign lim_b = SUM_W'({rsq_b_reg, SQ_FRAC_ZERO});

    assign hit_any = (en_a_reg && (sum_a <= lim_a)) || (en_b_reg && (sum_b <= lim_b));
    assign out_of_bounds = px_reg[POS_W-1] || (px_reg > X_LIMIT) ||
                           py_reg[POS_W-1] || (py_reg > Y_LIMIT);
    assign last_step  = (steps_reg == STEP_W'(MAX_STEPS - 1));
    assign drawn_next = (drawn_reg == DRAWN_MAX) ? drawn_reg : drawn_reg + 1'b1;
    assign out_free   = !result_valid_reg || result_ready;
    assign emit       = (state_reg == S_EMIT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ray_valid)
                    begin
                        px_reg    <= px_init;
                        py_reg    <= py_init;
                        dax_reg   <= px_init - $signed(POS_W'({cfg.a_x, FRAC_ZERO}));
                        day_reg   <= py_init - $signed(POS_W'({cfg.a_y, FRAC_ZERO}));
                        dbx_reg   <= px_init - $signed(POS_W'({cfg.b_x, FRAC_ZERO}));
                        dby_reg   <= py_init - $signed(POS_W'({cfg.b_y, FRAC_ZERO}));
                        rsq_a_reg <= RSQ_W'(cfg.a_radius) * RSQ_W'(cfg.a_radius);
                        rsq_b_reg <= RSQ_W'(cfg.b_radius) * RSQ_W'(cfg.b_radius);
                        en_a_reg  <= (cfg.count != '0);
                        en_b_reg  <= cfg.count[CNT_W-1];
                        steps_reg <= '0;
                        drawn_reg <= '0;
                        hit_reg   <= 1'b0;
                        cap_reg   <= 1'b0;
                        state_reg <= S_DIR;
                    end
                end
                S_DIR:
                begin
                    if (dir.valid)
                    begin
                        dir_x_reg <= dir.x;
                        dir_y_reg <= dir.y;
                        px_reg    <= px_reg + step_x;
                        py_reg    <= py_reg + step_y;
                        dax_reg   <= dax_reg + step_x;
                        day_reg   <= day_reg + step_y;
                        dbx_reg   <= dbx_reg + step_x;
                        dby_reg   <= dby_reg + step_y;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sq_ax_reg <= SQ_W'(mag_ax) * SQ_W'(mag_ax);
                    sq_ay_reg <= SQ_W'(mag_ay) * SQ_W'(mag_ay);
                    sq_bx_reg <= SQ_W'(mag_bx) * SQ_W'(mag_bx);
                    sq_by_reg <= SQ_W'(mag_by) * SQ_W'(mag_by);
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    // collision wins over drawing; the colliding point is not counted
                    priority if (hit_any)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else if (out_of_bounds)
                    begin
                        drawn_reg <= drawn_next;
                        state_reg <= S_EMIT;
                    end
                    else if (last_step)
                    begin
                        drawn_reg <= drawn_next;
                        cap_reg   <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        drawn_reg <= drawn_next;
                        steps_reg <= steps_reg + 1'b1;
                        px_reg    <= px_reg + step_x;
                        py_reg    <= py_reg + step_y;
                        dax_reg   <= dax_reg + step_x;
                        day_reg   <= day_reg + step_y;
                        dbx_reg   <= dbx_reg + step_x;
                        dby_reg   <= dby_reg + step_y;
                        state_reg <= S_SQ;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        end_x_reg     <= trunc_pixel(px_reg);
                        end_y_reg     <= trunc_pixel(py_reg);
                        hit_out_reg   <= hit_reg;
                        cap_out_reg   <= cap_reg;
                        drawn_out_reg <= drawn_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid     = result_valid_reg;
    assign end_x            = $signed(end_x_reg);
    assign end_y            = $signed(end_y_reg);
    assign hit              = hit_out_reg;
    assign drawn_points     = drawn_out_reg;
    assign step_cap_reached = cap_out_reg;

endmodule

### hdl/ray_march_circle_occlusion_checker.sv
`include "ray_march_circle_occlusion_macros.svh"

module ray_march_circle_occlusion_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              ray_valid,
    input logic                              ray_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [rmco_pkg::OUT_W-1:0] end_x,
    input logic signed [rmco_pkg::OUT_W-1:0] end_y,
    input logic                              hit,
    input logic [rmco_pkg::DRAWN_W-1:0]      drawn_points,
    input logic                              step_cap_reached
);
    import rmco_pkg::*;

    // a waiting result beat holds its end point and drawn count
    `RMCO_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(end_x) && $stable(end_y) && $stable(drawn_points), "result beat changed while stalled")

    // a march never ends with both a hit and the step cap
    `RMCO_ASSERT(a_flags_exclusive, clk, rst_n, result_valid |-> !(hit && step_cap_reached), "hit and step cap both set")

    // the block is busy right after taking a ray
    `RMCO_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, ray_valid && ray_ready, !ray_ready, "ray taken while a march is running")

    // leaving the screen always draws the last point
    `RMCO_ASSERT(a_edge_stop_drawn, clk, rst_n, (result_valid && !hit && !step_cap_reached) |-> (drawn_points != '0), "edge stop with no drawn point")

endmodule

bind ray_march_circle_occlusion ray_march_circle_occlusion_checker u_checker (.*);

### bench/ray_march_circle_occlusion_tb.sv
`timescale 1ns / 100ps

module ray_march_circle_occlusion_tb;

    import rmco_pkg::*;

    localparam int  CYCLE_LIMIT = 8_000_000;
    localparam int  PRINT_LIMIT = 100;
    localparam int  RANDOM_BATCHES = 6;
    localparam int  RAYS_PER_BATCH = 70;

    typedef struct {
        logic [XY_W-1:0]          ox;
        logic [XY_W-1:0]          oy;
        logic [IDX_W-1:0]         idx;
        logic signed [OUT_W-1:0]  ex;
        logic signed [OUT_W-1:0]  ey;
        logic                     hit;
        logic [DRAWN_W-1:0]       drawn;
        logic                     cap;
    } ray_end_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        ray_valid;
    logic                        ray_ready;
    logic [XY_W-1:0]             origin_x;
    logic [XY_W-1:0]             origin_y;
    logic [IDX_W-1:0]            ray_index;
    logic                        result_valid;
    logic                        result_ready;
    logic signed [OUT_W-1:0]     end_x;
    logic signed [OUT_W-1:0]     end_y;
    logic                        hit;
    logic [DRAWN_W-1:0]          drawn_points;
    logic                        step_cap_reached;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;

    obst_cfg_t  obst_cfg;
    ray_end_t   pending_ends[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         sender_gaps = 1'b1;
    bit         result_stalls = 1'b1;

    ray_march_circle_occlusion dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .ray_valid        (ray_valid),
        .ray_ready        (ray_ready),
        .origin_x         (origin_x),
        .origin_y         (origin_y),
        .ray_index        (ray_index),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .end_x            (end_x),
        .end_y            (end_y),
        .hit              (hit),
        .drawn_points     (drawn_points),
        .step_cap_reached (step_cap_reached),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL ray_march_circle_occlusion");
            $finish;
        end
    end

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic bit covers_point(input longint px, input longint py,
                                        input longint cx, input longint cy,
                                        input longint r);
        longint dx;
        longint dy;
        longint rr;
        dx = px - (cx <<< FRAC_W);
        dy = py - (cy <<< FRAC_W);
        rr = r <<< FRAC_W;
        return (dx * dx + dy * dy) <= (rr * rr);
    endfunction

    function automatic longint q16_to_pixel(input longint v);
        return (v >= 0) ? (v >>> FRAC_W) : -((-v) >>> FRAC_W);
    endfunction

    // Unit direction from the quarter-turn CORDIC, then one-pixel steps
    function automatic ray_end_t march_ray(input logic [XY_W-1:0] ox,
                                           input logic [XY_W-1:0] oy,
                                           input logic [IDX_W-1:0] idx);
        ray_end_t        res;
        longint unsigned phase;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          c;
        longint          s;
        longint          dx;
        longint          dy;
        longint          px;
        longint          py;
        int              quad;
        int              circles;
        int              drawn;
        bit              stopped_in;
        bit              capped;

        phase = ((64'(idx) % 64'(ANGLE_STEPS)) << 32) / 64'(ANGLE_STEPS);
        phase = phase & 64'hFFFF_FFFF;
        quad  = int'(phase >> 30);
        z     = longint'(phase & 64'h3FFF_FFFF);
        x     = longint'(CORDIC_GAIN);
        y     = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        c = (x + 8192) >>> ROUND_SHIFT;
        s = (y + 8192) >>> ROUND_SHIFT;
        case (quad)
            0: begin dx = c;  dy = s;  end
            1: begin dx = -s; dy = c;  end
            2: begin dx = -c; dy = -s; end
            default: begin dx = s; dy = -c; end
        endcase

        circles    = (obst_cfg.count > 2) ? 2 : int'(obst_cfg.count);
        px         = longint'(ox) <<< FRAC_W;
        py         = longint'(oy) <<< FRAC_W;
        drawn      = 0;
        stopped_in = 1'b0;
        capped     = 1'b1;
        for (int step = 0; step < MAX_STEPS_DEFAULT; step++)
        begin
            px = px + dx;
            py = py + dy;
            if ((circles >= 1 && covers_point(px, py, obst_cfg.a_x, obst_cfg.a_y,
                                              obst_cfg.a_radius)) ||
                (circles >= 2 && covers_point(px, py, obst_cfg.b_x, obst_cfg.b_y,
                                              obst_cfg.b_radius)))
            begin
                stopped_in = 1'b1;
                capped     = 1'b0;
                break;
            end
            if (drawn < DRAWN_MAX)
                drawn++;
            if (px < 0 || px > (longint'(SCREEN_WIDTH) <<< FRAC_W) ||
                py < 0 || py > (longint'(SCREEN_HEIGHT) <<< FRAC_W))
            begin
                capped = 1'b0;
                break;
            end
        end

        res.ox    = ox;
        res.oy    = oy;
        res.idx   = idx;
        res.ex    = OUT_W'(q16_to_pixel(px));
        res.ey    = OUT_W'(q16_to_pixel(py));
        res.hit   = stopped_in;
        res.drawn = DRAWN_W'(drawn);
        res.cap   = capped;
        return res;
    endfunction

    task automatic check_result();
        ray_end_t want;
        string    tag;
        if (pending_ends.size() == 0)
        begin
            report($sformatf("result beat with no ray outstanding (end %0d,%0d)",
                             end_x, end_y));
            return;
        end
        want = pending_ends.pop_front();
        tag  = $sformatf("ray (%0d,%0d) idx %0d", want.ox, want.oy, want.idx);
        if (end_x !== want.ex)
            report($sformatf("%s end_x: got %0d, expected %0d", tag, end_x, want.ex));
        if (end_y !== want.ey)
            report($sformatf("%s end_y: got %0d, expected %0d", tag, end_y, want.ey));
        if (hit !== want.hit)
            report($sformatf("%s hit: got %0b, expected %0b", tag, hit, want.hit));
        if (drawn_points !== want.drawn)
            report($sformatf("%s drawn_points: got %0d, expected %0d", tag,
                             drawn_points, want.drawn));
        if (step_cap_reached !== want.cap)
            report($sformatf("%s step_cap_reached: got %0b, expected %0b", tag,
                             step_cap_reached, want.cap));
    endtask

    // result side: check each beat, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_result();
        if (!rst_n)
            result_ready <= 1'b0;
        else if (!result_stalls)
            result_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) < 2)
        begin
            stall_left = pick_gap() - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // valid is left high after a beat; the next call either replaces the
    // payload in the same step or drops valid for a gap
    task automatic send_ray(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                            input logic [IDX_W-1:0] idx);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 9) < 4) ? pick_gap() : 0;
        if (gap > 0)
        begin
            ray_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_valid <= 1'b1;
        origin_x  <= x;
        origin_y  <= y;
        ray_index <= idx;
        do
            @(posedge clk);
        while (!ray_ready);
        pending_ends.push_back(march_ray(x, y, idx));
    endtask

    task automatic drain_rays();
        ray_valid <= 1'b0;
        while (pending_ends.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] field_mask(input reg_idx_t r);
        case (r)
            REG_OBST_COUNT:             return (1 << CNT_W) - 1;
            REG_A_RADIUS, REG_B_RADIUS: return (1 << RAD_W) - 1;
            default:                    return (1 << XY_W) - 1;
        endcase
    endfunction

    // setup + access write, then the same for a read back
    task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({r, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (r)
            REG_OBST_COUNT: obst_cfg.count    = value[CNT_W-1:0];
            REG_A_X:        obst_cfg.a_x      = value[XY_W-1:0];
            REG_A_Y:        obst_cfg.a_y      = value[XY_W-1:0];
            REG_A_RADIUS:   obst_cfg.a_radius = value[RAD_W-1:0];
            REG_B_X:        obst_cfg.b_x      = value[XY_W-1:0];
            REG_B_Y:        obst_cfg.b_y      = value[XY_W-1:0];
            REG_B_RADIUS:   obst_cfg.b_radius = value[RAD_W-1:0];
            default: ;
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== (value & field_mask(r)))
            report($sformatf("register %s read back 0x%0h, expected 0x%0h", r.name(),
                             got, value & field_mask(r)));
    endtask

    task automatic write_circles(input int ax, input int ay, input int ar,
                                 input int bx, input int by, input int br);
        write_reg(REG_A_X, ax);
        write_reg(REG_A_Y, ay);
        write_reg(REG_A_RADIUS, ar);
        write_reg(REG_B_X, bx);
        write_reg(REG_B_Y, by);
        write_reg(REG_B_RADIUS, br);
    endtask

    task automatic test_reset_defaults();
        send_ray(50, 50, 0);        // starts inside circle A
        send_ray(0, 0, 32);         // diagonal into circle A
        send_ray(400, 100, 64);     // straight down into circle B
        send_ray(800, 600, 0);      // bottom-right corner, leaves at once
        send_ray(0, 0, 128);        // goes negative on the first step
        send_ray(1023, 1023, 255);  // origin off screen, all ones
        send_ray(0, 600, 192);      // straight up the left edge
        send_ray(799, 1, 96);
        drain_rays();
    endtask

    task automatic test_obstacle_count();
        write_reg(REG_OBST_COUNT, 0);
        send_ray(400, 300, 0);      // through B's center, nothing enabled
        send_ray(0, 0, 32);
        drain_rays();
        write_reg(REG_OBST_COUNT, 1);
        send_ray(400, 100, 64);     // B disabled, runs to the bottom
        send_ray(0, 0, 32);
        drain_rays();
        write_reg(REG_OBST_COUNT, 3);   // acts as two
        send_ray(400, 100, 64);
        send_ray(0, 0, 32);
        drain_rays();
    endtask

    task automatic test_circle_extremes();
        write_reg(REG_OBST_COUNT, 2);
        write_circles(0, 0, 255, SCREEN_WIDTH, SCREEN_HEIGHT, 255);
        send_ray(0, 0, 0);
        send_ray(800, 600, 128);
        send_ray(400, 300, 32);
        send_ray(400, 300, 160);
        send_ray(400, 0, 64);
        drain_rays();
        // zero radius: only an exact landing on the center hits
        write_circles(100, 100, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 0);
        send_ray(0, 100, 0);
        send_ray(100, 0, 64);
        send_ray(700, 600, 0);
        drain_rays();
    endtask

    task automatic test_random_rays();
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        for (int b = 0; b < RANDOM_BATCHES; b++)
        begin
            drain_rays();
            write_reg(REG_OBST_COUNT, $urandom_range(0, 3));
            write_circles($urandom_range(0, SCREEN_WIDTH), $urandom_range(0, SCREEN_HEIGHT),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(10, 80),
                          $urandom_range(0, SCREEN_WIDTH), $urandom_range(0, SCREEN_HEIGHT),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(10, 80));
            // one batch runs flat out on both sides
            sender_gaps   = (b != 2);
            result_stalls = (b != 2);
            for (int i = 0; i < RAYS_PER_BATCH; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    x = XY_W'($urandom_range(0, SCREEN_WIDTH));
                    y = XY_W'($urandom_range(0, SCREEN_HEIGHT));
                end
                else
                begin
                    x = XY_W'($urandom_range(0, (1 << XY_W) - 1));
                    y = XY_W'($urandom_range(0, (1 << XY_W) - 1));
                end
                send_ray(x, y, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
                if ($urandom_range(0, 34) == 0)
                    drain_rays();   // let the pipe empty before the next beat
            end
        end
        sender_gaps   = 1'b1;
        result_stalls = 1'b1;
        drain_rays();
    endtask

    initial
    begin
        obst_cfg = '{count: RST_COUNT, a_x: RST_A_X, a_y: RST_A_Y, a_radius: RST_A_RADIUS,
                     b_x: RST_B_X, b_y: RST_B_Y, b_radius: RST_B_RADIUS};
        rst_n     <= 1'b0;
        ray_valid <= 1'b0;
        origin_x  <= '0;
        origin_y  <= '0;
        ray_index <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_obstacle_count();
        test_circle_extremes();
        test_random_rays();

        drain_rays();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS ray_march_circle_occlusion");
        else
            $display("FAIL ray_march_circle_occlusion");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/rmco_pkg.sv
hdl/rmco_regs.sv
hdl/rmco_cordic.sv
hdl/rmco_march.sv
hdl/ray_march_circle_occlusion.sv
hdl/ray_march_circle_occlusion_checker.sv
bench/ray_march_circle_occlusion_tb.sv
